// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the history unit's RTL, included by wmm_back.
// The sampling clock is i_clk, and reset (i_rst_n low) disables every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define WMM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define WMM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wmm_pkg.sv =====
// Shared types, constants and helper functions for the windowed min/max/average unit.
// Depends on nothing; wmm_div, wmm_front, wmm_back and the top module import it.
`timescale 1ns / 1ps

package wmm_pkg;

    // History geometry.
    localparam int HISTORY_DEPTH = 64;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int OFF_W         = 6;
    localparam int IDX_W         = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;
    localparam int CMP_W         = (CNT_W > OFF_W) ? CNT_W : OFF_W;

    // Field widths.
    localparam int TIME_W = 32;
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 32;
    localparam int NSMP_W = 16;
    localparam int REC_W  = 3 * VAL_W;

    // Serial divider geometry: magnitude plus half the count, over the count.
    localparam int DIVIDEND_W = SUM_W + 1;
    localparam int DIVISOR_W  = NSMP_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset values and limits.
    localparam logic [TIME_W-1:0]        PERIOD_RESET = 32'd60000;
    localparam logic signed [VAL_W-1:0]  MIN_RESET    = 16'sd32767;
    localparam logic signed [VAL_W-1:0]  MAX_RESET    = -16'sd2048;
    localparam logic [NSMP_W-1:0]        SAMPLES_MAX  = '1;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_DROP   = 2'd3
    } t_cmd;

    // One classified request travelling from the front to the back.
    typedef struct packed {
        t_cmd                     cmd;
        logic [TIME_W-1:0]        now_ms;
        logic signed [VAL_W-1:0]  value;
        logic [OFF_W-1:0]         offset;
    } t_op;

    // One result as held in the output register.
    typedef struct packed {
        logic                     ok;
        logic                     window_closed;
        logic signed [VAL_W-1:0]  average;
        logic signed [VAL_W-1:0]  minimum;
        logic signed [VAL_W-1:0]  maximum;
        logic [CNT_W-1:0]         stored_count;
    } t_result;

    // Step a history pointer round the ring.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Step a queue pointer round its ring.
    function automatic logic [QPTR_W-1:0] queue_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/core/wmm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the history records of the unit.
`timescale 1ns / 1ps

module wmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/wmm_div.sv =====
// Restoring serial divider for the window average, one quotient bit per cycle.
// Depends on wmm_pkg for the operand widths.
`timescale 1ns / 1ps

module wmm_div
    import wmm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [VAL_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_dq;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;

    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_sub;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        rem_sh  = {r_rem, r_dq[DIVIDEND_W-1]};
        fits    = (rem_sh >= {1'b0, r_divisor});
        rem_sub = rem_sh - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq      <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq[VAL_W-1:0];

endmodule

// ===== rtl/core/wmm_front.sv =====
// Front end: accepts requests, classifies the command and queues them for the back.
// Depends on wmm_pkg for the request type and queue geometry.
`timescale 1ns / 1ps

module wmm_front
    import wmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_cmd,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [VAL_W-1:0]  i_sample_value,
    input  logic [OFF_W-1:0]  i_peek_offset,
    output logic              o_op_valid,
    output t_op               o_op,
    input  logic              i_op_take
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_fill;

    t_op  in_op;
    logic do_push;
    logic do_pop;

    // Classify the incoming request.
    always_comb begin
        in_op.cmd    = t_cmd'(i_cmd);
        in_op.now_ms = i_now_ms;
        in_op.value  = $signed(i_sample_value);
        in_op.offset = (in_op.cmd == CMD_PEEK) ? i_peek_offset : '0;
    end

    assign full    = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = i_op_take && (r_fill != '0);

    // Queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_tail <= queue_next(r_tail);
            end
            if (do_pop) begin
                r_head <= queue_next(r_head);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_tail] <= in_op;
        end
    end

    assign o_op_valid = (r_fill != '0);
    assign o_op       = r_slot[r_head];

endmodule

// ===== rtl/core/wmm_back.sv =====
// Back end: window accumulation, history ring, serial average and the result register.
// Depends on wmm_pkg, wmm_div, wmm_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wmm_back
    import wmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [TIME_W-1:0] i_cfg_data,
    input  logic              i_op_valid,
    input  t_op               i_op,
    output logic              o_op_take,
    input  logic              i_res_pop,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ
    } t_state;

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [TIME_W-1:0]       r_period, n_period;
    logic [PTR_W-1:0]        r_wp, n_wp;
    logic [PTR_W-1:0]        r_rp, n_rp;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [TIME_W-1:0]       r_start, n_start;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [NSMP_W-1:0]       r_samples, n_samples;
    logic signed [VAL_W-1:0] r_min, n_min;
    logic signed [VAL_W-1:0] r_max, n_max;
    logic                    r_res_valid, n_res_valid;
    t_result                 r_res, n_res;

    logic                    take;
    logic [TIME_W-1:0]       elapsed;
    logic [IDX_W-1:0]        idx_sum;
    logic [IDX_W-1:0]        idx_wrap;
    logic [SUM_W-1:0]        sum_mag;
    logic [DIVIDEND_W-1:0]   dividend;
    logic signed [VAL_W-1:0] avg;

    logic                    div_start;
    logic                    div_done;
    logic [VAL_W-1:0]        div_q;

    logic                    ram_we;
    logic [REC_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [PTR_W-1:0]        ram_raddr;
    logic [REC_W-1:0]        ram_rdata;

    wmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_samples),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    wmm_ram #(
        .WIDTH (REC_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Operands that do not depend on the state machine.
    always_comb begin
        take     = (r_state == S_IDLE) && i_op_valid && !r_res_valid;
        elapsed  = i_op.now_ms - r_start;
        idx_sum  = IDX_W'(r_rp) + IDX_W'(i_op.offset);
        idx_wrap = (idx_sum >= IDX_W'(HISTORY_DEPTH)) ? idx_sum - IDX_W'(HISTORY_DEPTH)
                                                      : idx_sum;
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        dividend = {1'b0, sum_mag} + DIVIDEND_W'(r_samples >> 1);
        if (r_samples == '0) begin
            avg = '0;
        end else if (r_sum[SUM_W-1]) begin
            avg = -$signed(div_q);
        end else begin
            avg = $signed(div_q);
        end
    end

    // Next-state and datapath decisions.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_period    = i_cfg_valid ? i_cfg_data : r_period;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_count     = r_count;
        n_start     = r_start;
        n_sum       = r_sum;
        n_samples   = r_samples;
        n_min       = r_min;
        n_max       = r_max;
        n_res_valid = r_res_valid && !i_res_pop;
        n_res       = r_res;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = {avg, r_min, r_max};
        ram_re      = 1'b0;
        ram_raddr   = r_rp;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_op                  = i_op;
                    n_res                 = '0;
                    n_res.stored_count    = r_count;
                    case (i_op.cmd)
                        CMD_SAMPLE: begin
                            n_res.ok = 1'b1;
                            if (elapsed > r_period) begin
                                // The window closes: the average goes through the divider.
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end else begin
                                if (r_samples != SAMPLES_MAX) begin
                                    n_sum     = r_sum + SUM_W'(i_op.value);
                                    n_samples = r_samples + 1'b1;
                                end
                                if (i_op.value < r_min) begin
                                    n_min = i_op.value;
                                end
                                if (i_op.value > r_max) begin
                                    n_max = i_op.value;
                                end
                                n_res_valid = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (r_count != '0) begin
                                ram_re             = 1'b1;
                                n_rp               = ring_next(r_rp);
                                n_count            = r_count - 1'b1;
                                n_res.ok           = 1'b1;
                                n_res.stored_count = r_count - 1'b1;
                                n_state            = S_READ;
                            end else begin
                                n_res_valid = 1'b1;
                            end
                        end
                        CMD_PEEK: begin
                            if (CMP_W'(r_count) > CMP_W'(i_op.offset)) begin
                                ram_re    = 1'b1;
                                ram_raddr = idx_wrap[PTR_W-1:0];
                                n_res.ok  = 1'b1;
                                n_state   = S_READ;
                            end else begin
                                n_res_valid = 1'b1;
                            end
                        end
                        CMD_DROP: begin
                            if (r_count != '0) begin
                                n_rp               = ring_next(r_rp);
                                n_count            = r_count - 1'b1;
                                n_res.ok           = 1'b1;
                                n_res.stored_count = r_count - 1'b1;
                            end
                            n_res_valid = 1'b1;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    // Store the record, then open the next window with the closing sample.
                    ram_we               = 1'b1;
                    n_wp                 = ring_next(r_wp);
                    if (r_count < CNT_W'(HISTORY_DEPTH)) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_rp = ring_next(r_rp);
                    end
                    n_res.window_closed  = 1'b1;
                    n_res.average        = avg;
                    n_res.minimum        = r_min;
                    n_res.maximum        = r_max;
                    n_res.stored_count   = (r_count < CNT_W'(HISTORY_DEPTH)) ? r_count + 1'b1
                                                                             : r_count;
                    n_res_valid          = 1'b1;
                    n_start              = r_op.now_ms;
                    n_sum                = SUM_W'(r_op.value);
                    n_samples            = NSMP_W'(1);
                    n_min                = r_op.value;
                    n_max                = r_op.value;
                    n_state              = S_IDLE;
                end
            end
            S_READ: begin
                n_res.average = $signed(ram_rdata[REC_W-1 -: VAL_W]);
                n_res.minimum = $signed(ram_rdata[2*VAL_W-1 -: VAL_W]);
                n_res.maximum = $signed(ram_rdata[VAL_W-1:0]);
                n_res_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_RESET;
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_start     <= '0;
            r_sum       <= '0;
            r_samples   <= '0;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_count     <= n_count;
            r_start     <= n_start;
            r_sum       <= n_sum;
            r_samples   <= n_samples;
            r_min       <= n_min;
            r_max       <= n_max;
            r_res_valid <= n_res_valid;
        end
        r_op  <= n_op;
        r_res <= n_res;
    end

    assign o_op_take   = take;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `WMM_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(HISTORY_DEPTH), "record count above depth")
    `WMM_ASSERT_ALWAYS(a_done_in_div, !div_done || r_state == S_DIV, "divider done outside divide")
    `WMM_ASSERT_IMP(a_read_capture, ram_re, r_state == S_READ && !r_res_valid, "read data lost")

endmodule

// ===== rtl/core/windowed_min_max_avg_history_unit.sv =====
// Windowed minimum/maximum/average recorder with a 64-record overwriting history.
// A request is taken while full is low; results leave in request order, one per request,
// through the empty/pop side. A sample that stays in the window needs no divider; a pop or
// peek reads the history RAM, which has a registered read, and a sample that closes the
// window waits for the serial divider that forms the rounded average one quotient bit per
// cycle over 33 steps. Two requests can queue while the back end works,
// and a finished result waits in the output register. The history needs no clearing pass.
// Depends on wmm_pkg, wmm_front and wmm_back.
`timescale 1ns / 1ps

module windowed_min_max_avg_history_unit
    import wmm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [TIME_W-1:0]       i_cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_cmd,
    input  logic [TIME_W-1:0]       i_now_ms,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [OFF_W-1:0]        i_peek_offset,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_ok,
    output logic                    o_window_closed,
    output logic signed [VAL_W-1:0] o_average,
    output logic signed [VAL_W-1:0] o_minimum,
    output logic signed [VAL_W-1:0] o_maximum,
    output logic [CNT_W-1:0]        o_stored_count
);

    logic    op_valid;
    t_op     op;
    logic    op_take;
    logic    res_valid;
    t_result res;

    wmm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_now_ms       (i_now_ms),
        .i_sample_value (i_sample_value),
        .i_peek_offset  (i_peek_offset),
        .o_op_valid     (op_valid),
        .o_op           (op),
        .i_op_take      (op_take)
    );

    wmm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_op_valid  (op_valid),
        .i_op        (op),
        .o_op_take   (op_take),
        .i_res_pop   (pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The period register takes a write in any cycle.
    assign o_cfg_ready     = 1'b1;
    assign empty           = !res_valid;
    assign o_ok            = res.ok;
    assign o_window_closed = res.window_closed;
    assign o_average       = res.average;
    assign o_minimum       = res.minimum;
    assign o_maximum       = res.maximum;
    assign o_stored_count  = res.stored_count;

endmodule
